/* sv/twws_pkg.sv */
// Shared types and constants for the timed window weighted statistics unit.
// Holds the result status codes, datapath ops, controller states and the
// command and status structs. No dependencies.
package twws_pkg;

  localparam int DEPTH_DEF  = 1024;
  localparam int SCORE_W    = 16;
  localparam int WEIGHT_W   = 16;
  localparam int STAMP_W    = 32;
  localparam int WWIN_W     = 26;
  localparam int CNT_W      = 6;
  localparam int MEAN_STEPS = 16;
  localparam int VAR_STEPS  = 32;
  localparam int SQRT_STEPS = 16;

  typedef enum logic [2:0] {
    STAT_OK     = 3'd0,
    STAT_NODATA = 3'd1,
    STAT_ZEROW  = 3'd2,
    STAT_ADDED  = 3'd3,
    STAT_FULL   = 3'd4
  } stat_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_ADD_RD,
    OP_ADD_MUL1,
    OP_ADD_MUL2,
    OP_ADD_WR,
    OP_RD0,
    OP_T0,
    OP_RD_LAST,
    OP_S_CHKN,
    OP_RD_MID,
    OP_S_CMP,
    OP_S_FIN,
    OP_RD_IDX,
    OP_LATE,
    OP_EARLY,
    OP_MAG,
    OP_DIVM_LD,
    OP_DIV_STEP,
    OP_MEAN,
    OP_M1_LD,
    OP_M2_LD,
    OP_M3_LD,
    OP_MUL_STEP,
    OP_DIVV_LD,
    OP_SQ_LD,
    OP_SQ_STEP
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ADD_RD,
    S_ADD_M1,
    S_ADD_M2,
    S_ADD_WR,
    S_Q_RD0,
    S_Q_T0,
    S_S_RDN,
    S_S_CHKN,
    S_S_LOOP,
    S_S_CMP,
    S_RD_IDX,
    S_Q_LATE,
    S_Q_EARLY,
    S_Q_CHKW,
    S_DIVM_LD,
    S_DIVM_RUN,
    S_MEAN,
    S_M1_LD,
    S_M1_RUN,
    S_M2_LD,
    S_M2_RUN,
    S_M3_LD,
    S_M3_RUN,
    S_DIVV_LD,
    S_DIVV_RUN,
    S_SQ_LD,
    S_SQ_RUN,
    S_RES
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t op;
    logic   res_en;
    stat_t  res_code;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic t0_late;
    logic hit;
    logic more;
    logic start_early;
    logic w_nonpos;
    logic s2_neg;
    logic num_neg;
    logic last;
  } dp_stat_t;

endpackage

/* sv/twws_ctrl.sv */
// Sequencing state machine for the timed window weighted statistics unit.
// Issues one datapath op per cycle from datapath status; uses twws_pkg.
module twws_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               in_cmd,
  input  twws_pkg::dp_stat_t stat,
  output twws_pkg::dp_cmd_t  cmd,
  output logic               busy
);
  import twws_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        second_r, second_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      second_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      second_r <= second_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    second_nxt   = second_r;
    cmd.op       = OP_NONE;
    cmd.res_en   = 1'b0;
    cmd.res_code = STAT_OK;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op     = OP_LOAD;
          second_nxt = 1'b0;
          state_nxt  = in_cmd ? S_Q_RD0 : S_ADD_RD;
        end
      end
      S_ADD_RD: begin
        if (stat.full) begin
          cmd.res_en   = 1'b1;
          cmd.res_code = STAT_FULL;
          state_nxt    = S_IDLE;
        end else begin
          cmd.op    = OP_ADD_RD;
          state_nxt = S_ADD_M1;
        end
      end
      S_ADD_M1: begin
        cmd.op    = OP_ADD_MUL1;
        state_nxt = S_ADD_M2;
      end
      S_ADD_M2: begin
        cmd.op    = OP_ADD_MUL2;
        state_nxt = S_ADD_WR;
      end
      S_ADD_WR: begin
        cmd.op       = OP_ADD_WR;
        cmd.res_en   = 1'b1;
        cmd.res_code = STAT_ADDED;
        state_nxt    = S_IDLE;
      end
      S_Q_RD0: begin
        if (stat.empty) begin
          cmd.res_en   = 1'b1;
          cmd.res_code = STAT_NODATA;
          state_nxt    = S_IDLE;
        end else begin
          cmd.op    = OP_RD0;
          state_nxt = S_Q_T0;
        end
      end
      S_Q_T0: begin
        if (stat.t0_late) begin
          cmd.res_en   = 1'b1;
          cmd.res_code = STAT_NODATA;
          state_nxt    = S_IDLE;
        end else begin
          cmd.op    = OP_T0;
          state_nxt = S_S_RDN;
        end
      end
      S_S_RDN: begin
        cmd.op    = OP_RD_LAST;
        state_nxt = S_S_CHKN;
      end
      S_S_CHKN: begin
        cmd.op    = OP_S_CHKN;
        state_nxt = stat.hit ? S_RD_IDX : S_S_LOOP;
      end
      S_S_LOOP: begin
        if (stat.more) begin
          cmd.op    = OP_RD_MID;
          state_nxt = S_S_CMP;
        end else begin
          cmd.op    = OP_S_FIN;
          state_nxt = S_RD_IDX;
        end
      end
      S_S_CMP: begin
        cmd.op    = OP_S_CMP;
        state_nxt = S_S_LOOP;
      end
      S_RD_IDX: begin
        cmd.op    = OP_RD_IDX;
        state_nxt = second_r ? S_Q_EARLY : S_Q_LATE;
      end
      S_Q_LATE: begin
        cmd.op = OP_LATE;
        if (stat.start_early) begin
          state_nxt = S_Q_CHKW;
        end else begin
          second_nxt = 1'b1;
          state_nxt  = S_S_RDN;
        end
      end
      S_Q_EARLY: begin
        cmd.op    = OP_EARLY;
        state_nxt = S_Q_CHKW;
      end
      S_Q_CHKW: begin
        if (stat.w_nonpos) begin
          cmd.res_en   = 1'b1;
          cmd.res_code = STAT_ZEROW;
          state_nxt    = S_IDLE;
        end else begin
          cmd.op    = OP_MAG;
          state_nxt = S_DIVM_LD;
        end
      end
      S_DIVM_LD: begin
        cmd.op    = OP_DIVM_LD;
        state_nxt = S_DIVM_RUN;
      end
      S_DIVM_RUN: begin
        cmd.op = OP_DIV_STEP;
        if (stat.last) state_nxt = S_MEAN;
      end
      S_MEAN: begin
        cmd.op    = OP_MEAN;
        state_nxt = stat.s2_neg ? S_RES : S_M1_LD;
      end
      S_M1_LD: begin
        cmd.op    = OP_M1_LD;
        state_nxt = S_M1_RUN;
      end
      S_M1_RUN: begin
        cmd.op = OP_MUL_STEP;
        if (stat.last) state_nxt = S_M2_LD;
      end
      S_M2_LD: begin
        cmd.op    = OP_M2_LD;
        state_nxt = S_M2_RUN;
      end
      S_M2_RUN: begin
        cmd.op = OP_MUL_STEP;
        if (stat.last) state_nxt = S_M3_LD;
      end
      S_M3_LD: begin
        cmd.op    = OP_M3_LD;
        state_nxt = S_M3_RUN;
      end
      S_M3_RUN: begin
        cmd.op = OP_MUL_STEP;
        if (stat.last) state_nxt = S_DIVV_LD;
      end
      S_DIVV_LD: begin
        if (stat.num_neg) begin
          state_nxt = S_RES;
        end else begin
          cmd.op    = OP_DIVV_LD;
          state_nxt = S_DIVV_RUN;
        end
      end
      S_DIVV_RUN: begin
        cmd.op = OP_DIV_STEP;
        if (stat.last) state_nxt = S_SQ_LD;
      end
      S_SQ_LD: begin
        cmd.op    = OP_SQ_LD;
        state_nxt = S_SQ_RUN;
      end
      S_SQ_RUN: begin
        cmd.op = OP_SQ_STEP;
        if (stat.last) state_nxt = S_RES;
      end
      S_RES: begin
        cmd.res_en   = 1'b1;
        cmd.res_code = STAT_OK;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* sv/twws_dpath.sv */
// Datapath for the timed window weighted statistics unit: sample table,
// search registers, digit multiplier, restoring divider and square root.
// Uses twws_pkg; driven one op per cycle by twws_ctrl.
module twws_dpath #(
  parameter int DEPTH = twws_pkg::DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  twws_pkg::dp_cmd_t          cmd,
  output twws_pkg::dp_stat_t         stat,
  input  logic                       in_cmd,
  input  logic signed [15:0]         in_score,
  input  logic [15:0]                in_weight,
  input  logic [31:0]                in_stamp,
  input  logic                       in_strictly_earlier,
  output logic                       out_valid,
  output logic signed [15:0]         out_mean,
  output logic [15:0]                out_std_dev,
  output logic [25:0]                out_window_weight,
  output twws_pkg::stat_t            out_status
);
  import twws_pkg::*;

  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int WPW = WEIGHT_W + AW;
  localparam int SPW = SCORE_W + WEIGHT_W + AW;
  localparam int QPW = 2 * SCORE_W + WEIGHT_W + AW;
  localparam int MW  = STAMP_W + WPW + SPW + QPW;
  localparam int T_LO = WPW + SPW + QPW;
  localparam int W_LO = SPW + QPW;
  localparam int S_LO = QPW;
  localparam int MA  = QPW;
  localparam int MD  = (SPW + 1 + 15) / 16;
  localparam int MBP = MD * 16;
  localparam int PW  = MA + MBP;
  localparam int DRW = 2 * WPW;
  localparam int XW  = SPW + 2;
  localparam longint WWIN_MAX = (64'd1 << WWIN_W) - 64'd1;

  // sample table
  logic [MW-1:0] mem [DEPTH];
  logic [MW-1:0] rd_r;
  logic [MW-1:0] wdata;
  logic [AW-1:0] raddr;
  logic          re;
  logic          we;

  logic                  cmd_r;
  logic signed [15:0]    score_r;
  logic [15:0]           weight_r;
  logic [31:0]           stamp_r;
  logic                  strict_r;
  logic [CW-1:0]         count_r;
  logic [CW-1:0]         nm1;

  logic signed [33:0]    target_r;
  logic [AW-1:0]         lo_r, hi_r, mid_r, idx_r;
  logic [AW:0]           mid_sum;
  logic [AW-1:0]         mid_c;
  logic [31:0]           thi_r, t0_r;

  logic signed [32:0]    sw_r;
  logic [31:0]           sq_r;
  logic [47:0]           ssw_r;

  logic signed [SPW:0]   s1_r;
  logic signed [QPW:0]   s2_r;
  logic signed [WPW:0]   w_r;
  logic                  neg_r;
  logic [SPW:0]          mag_r;

  logic [MA-1:0]         ma_r;
  logic [MBP-1:0]        mb_r;
  logic [PW-1:0]         acc_r, num_r;
  logic                  num_neg_r;
  logic [MA+15:0]        pp_c;

  logic [DRW-1:0]        den_r, rem_r;
  logic [31:0]           qlow_r;
  logic                  sat_r;
  logic [DRW:0]          r2_c;
  logic                  ge_c;

  logic [31:0]           sq_v_r, sq_res_r, sq_bit_r;
  logic [32:0]           sq_t_c;

  logic [CNT_W-1:0]      cnt_r;
  logic signed [15:0]    mean_r;

  logic [31:0]           rd_t;
  logic [WPW-1:0]        rd_w;
  logic signed [SPW-1:0] rd_s1;
  logic [QPW-1:0]        rd_s2;
  logic signed [33:0]    start_c;
  logic [XW-1:0]         x_c;
  logic [XW-17:0]        x_hi;
  logic [PW-33:0]        num_hi;
  logic [15:0]           q_c;
  logic                  sat_flag;

  logic                  out_valid_r;
  logic signed [15:0]    out_mean_r;
  logic [15:0]           out_sd_r;
  logic [25:0]           out_ww_r;
  stat_t                 out_status_r;

  assign rd_t  = rd_r[T_LO +: STAMP_W];
  assign rd_w  = rd_r[W_LO +: WPW];
  assign rd_s1 = $signed(rd_r[S_LO +: SPW]);
  assign rd_s2 = rd_r[0 +: QPW];
  assign nm1   = count_r - CW'(1);

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_c   = mid_sum[AW:1];
  assign start_c = $signed({1'b0, rd_t, 1'b0}) - $signed({2'b00, stamp_r});
  assign x_c     = XW'(mag_r) + XW'($unsigned(w_r) >> 1);
  assign x_hi    = x_c[XW-1:16];
  assign num_hi  = num_r[PW-1:32];
  assign pp_c    = ma_r * mb_r[MBP-1 -: 16];
  assign r2_c    = {rem_r, qlow_r[31]};
  assign ge_c    = (r2_c >= {1'b0, den_r});
  assign sq_t_c  = {1'b0, sq_res_r} + {1'b0, sq_bit_r};
  assign q_c     = qlow_r[15:0];

  // status toward the controller
  assign stat.empty       = (count_r == '0);
  assign stat.full        = (count_r == CW'(DEPTH));
  assign stat.t0_late     = (rd_t >= stamp_r);
  assign stat.hit         = ($signed({2'b00, rd_t}) < target_r);
  assign stat.more        = ({1'b0, hi_r} > ({1'b0, lo_r} + (AW+1)'(1)));
  assign stat.start_early = (start_c < $signed({2'b00, t0_r}));
  assign stat.w_nonpos    = (w_r <= 0);
  assign stat.s2_neg      = s2_r[QPW];
  assign stat.num_neg     = num_neg_r;
  assign stat.last        = (cnt_r == CNT_W'(1));

  // table address and write word
  always_comb begin
    raddr = '0;
    re    = 1'b0;
    case (cmd.op)
      OP_ADD_RD, OP_RD_LAST: begin
        raddr = nm1[AW-1:0];
        re    = 1'b1;
      end
      OP_RD0: begin
        re = 1'b1;
      end
      OP_RD_MID: begin
        raddr = mid_c;
        re    = 1'b1;
      end
      OP_RD_IDX: begin
        raddr = idx_r;
        re    = 1'b1;
      end
      default: begin
        re = 1'b0;
      end
    endcase
  end

  assign we = (cmd.op == OP_ADD_WR);

  always_comb begin
    logic signed [SPW-1:0] p1;
    logic [QPW-1:0]        p2;
    logic [WPW-1:0]        pw;
    p1 = (count_r == '0) ? '0 : rd_s1;
    p2 = (count_r == '0) ? '0 : rd_s2;
    pw = (count_r == '0) ? '0 : rd_w;
    wdata = {stamp_r,
             pw + WPW'(weight_r),
             p1 + SPW'(sw_r),
             p2 + QPW'(ssw_r)};
  end

  always_ff @(posedge clk) begin
    if (we) mem[count_r[AW-1:0]] <= wdata;
    if (re) rd_r <= mem[raddr];
  end

  // mean saturation
  always_comb begin
    sat_flag = 1'b0;
    if (neg_r) sat_flag = sat_r || (q_c > 16'd32768);
    else       sat_flag = sat_r || (q_c > 16'd32767);
  end

  // count and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.res_en;
      if (we) count_r <= count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_en) begin
      out_status_r <= cmd.res_code;
      if (cmd.res_code == STAT_OK) begin
        out_mean_r <= mean_r;
        out_sd_r   <= sq_res_r[15:0];
        out_ww_r   <= (64'($unsigned(w_r)) > WWIN_MAX) ? '1 : 26'($unsigned(w_r));
      end else begin
        out_mean_r <= '0;
        out_sd_r   <= '0;
        out_ww_r   <= '0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        cmd_r    <= in_cmd;
        score_r  <= in_score;
        weight_r <= in_weight;
        stamp_r  <= in_stamp;
        strict_r <= in_strictly_earlier;
      end
      OP_ADD_MUL1: begin
        sw_r <= score_r * $signed({1'b0, weight_r});
        sq_r <= 32'(score_r) * 32'(score_r);
      end
      OP_ADD_MUL2: begin
        ssw_r <= sq_r * weight_r;
      end
      OP_T0: begin
        t0_r     <= rd_t;
        target_r <= $signed({2'b00, stamp_r});
      end
      OP_S_CHKN: begin
        if (stat.hit) begin
          idx_r <= nm1[AW-1:0];
        end else begin
          lo_r  <= '0;
          hi_r  <= nm1[AW-1:0];
          thi_r <= rd_t;
        end
      end
      OP_RD_MID: begin
        mid_r <= mid_c;
      end
      OP_S_CMP: begin
        if (stat.hit) begin
          lo_r <= mid_r;
        end else begin
          hi_r  <= mid_r;
          thi_r <= rd_t;
        end
      end
      OP_S_FIN: begin
        if (strict_r || (target_r < $signed({2'b00, thi_r}))) idx_r <= lo_r;
        else                                                  idx_r <= hi_r;
      end
      OP_LATE: begin
        s1_r     <= {rd_s1[SPW-1], rd_s1};
        s2_r     <= {1'b0, rd_s2};
        w_r      <= {1'b0, rd_w};
        target_r <= start_c;
        strict_r <= 1'b1;
      end
      OP_EARLY: begin
        s1_r <= s1_r - {rd_s1[SPW-1], rd_s1};
        s2_r <= s2_r - $signed({1'b0, rd_s2});
        w_r  <= w_r - $signed({1'b0, rd_w});
      end
      OP_MAG: begin
        neg_r <= s1_r[SPW];
        mag_r <= s1_r[SPW] ? $unsigned(-s1_r) : $unsigned(s1_r);
      end
      OP_DIVM_LD: begin
        sat_r  <= (x_hi >= $unsigned(w_r));
        rem_r  <= DRW'(x_hi);
        qlow_r <= {x_c[15:0], 16'h0000};
        den_r  <= DRW'($unsigned(w_r));
        cnt_r  <= CNT_W'(MEAN_STEPS);
      end
      OP_DIV_STEP: begin
        rem_r  <= ge_c ? DRW'(r2_c - {1'b0, den_r}) : DRW'(r2_c);
        qlow_r <= {qlow_r[30:0], ge_c};
        cnt_r  <= cnt_r - CNT_W'(1);
      end
      OP_MEAN: begin
        sq_res_r <= '0;
        if (sat_flag) mean_r <= neg_r ? 16'sh8000 : 16'sh7FFF;
        else          mean_r <= neg_r ? $signed(16'(16'd0 - q_c)) : $signed(q_c);
      end
      OP_M1_LD: begin
        ma_r  <= MA'($unsigned(s2_r));
        mb_r  <= MBP'($unsigned(w_r));
        acc_r <= '0;
        cnt_r <= CNT_W'(MD);
      end
      OP_M2_LD: begin
        num_r <= acc_r;
        ma_r  <= MA'(mag_r);
        mb_r  <= MBP'(mag_r);
        acc_r <= '0;
        cnt_r <= CNT_W'(MD);
      end
      OP_M3_LD: begin
        num_neg_r <= (num_r < acc_r);
        num_r     <= num_r - acc_r;
        ma_r      <= MA'($unsigned(w_r));
        mb_r      <= MBP'($unsigned(w_r));
        acc_r     <= '0;
        cnt_r     <= CNT_W'(MD);
      end
      OP_MUL_STEP: begin
        // most significant digit first: shift the sum, add the next partial
        acc_r <= (acc_r << 16) + PW'(pp_c);
        mb_r  <= mb_r << 16;
        cnt_r <= cnt_r - CNT_W'(1);
      end
      OP_DIVV_LD: begin
        sat_r  <= (num_hi >= acc_r);
        rem_r  <= DRW'(num_hi);
        qlow_r <= num_r[31:0];
        den_r  <= DRW'(acc_r);
        cnt_r  <= CNT_W'(VAR_STEPS);
      end
      OP_SQ_LD: begin
        sq_v_r   <= sat_r ? 32'hFFFF_FFFF : qlow_r;
        sq_res_r <= '0;
        sq_bit_r <= 32'h4000_0000;
        cnt_r    <= CNT_W'(SQRT_STEPS);
      end
      OP_SQ_STEP: begin
        if ({1'b0, sq_v_r} >= sq_t_c) begin
          sq_v_r   <= sq_v_r - sq_t_c[31:0];
          sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
        end else begin
          sq_res_r <= sq_res_r >> 1;
        end
        sq_bit_r <= sq_bit_r >> 2;
        cnt_r    <= cnt_r - CNT_W'(1);
      end
      default: begin
        cmd_r <= cmd_r;
      end
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_mean          = out_mean_r;
  assign out_std_dev       = out_sd_r;
  assign out_window_weight = out_ww_r;
  assign out_status        = out_status_r;

endmodule

/* sv/timed_window_weighted_stats_unit.sv */
// Top level of the timed window weighted statistics unit.
// Joins twws_ctrl and twws_dpath; uses twws_pkg.
//
// Input: drive in_* and pulse start; the transfer happens on a rising
// edge with start high and busy low. in_cmd = 0 appends a sample, 1 queries.
// Output: out_valid is high for exactly one cycle with out_* holding the
// result; the receiver takes it in that cycle and cannot stall the block.
// Sequence: an add reads the last entry, forms the products and writes the
// new entry, or reports full at once on a full table. A query ends with no
// data on an empty table or when the stamp is at or before the first sample;
// otherwise it runs the first-sample check, a binary search per window edge
// (the second search is skipped when the window reaches back past the first
// sample), the weight check, the mean divider, the multiplier passes (MD = 3
// at the default depth), the variance divider and the square root, then
// issues the result. busy drops at the edge that raises out_valid, so the
// next item can transfer in the result cycle.
// Reset (rst_n low, synchronous) empties the table by clearing the sample
// count; table contents are not cleared and need no sweep.
module timed_window_weighted_stats_unit #(
  parameter int DEPTH = twws_pkg::DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_cmd,
  input  logic signed [15:0]    in_score,
  input  logic [15:0]           in_weight,
  input  logic [31:0]           in_stamp,
  input  logic                  in_strictly_earlier,
  output logic                  out_valid,
  output logic signed [15:0]    out_mean,
  output logic [15:0]           out_std_dev,
  output logic [25:0]           out_window_weight,
  output twws_pkg::stat_t       out_status
);
  import twws_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: one datapath op per cycle
  twws_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_cmd),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  // table, search and arithmetic; holds the result register
  twws_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_cmd              (in_cmd),
    .in_score            (in_score),
    .in_weight           (in_weight),
    .in_stamp            (in_stamp),
    .in_strictly_earlier (in_strictly_earlier),
    .out_valid           (out_valid),
    .out_mean            (out_mean),
    .out_std_dev         (out_std_dev),
    .out_window_weight   (out_window_weight),
    .out_status          (out_status)
  );

endmodule

/* sv/twws_checker.sv */
// Port-level checks for the timed window weighted statistics unit,
// attached to the top level by bind. Uses twws_pkg.
module twws_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input logic signed [15:0]  out_mean,
  input logic [15:0]         out_std_dev,
  input logic [25:0]         out_window_weight,
  input twws_pkg::stat_t     out_status
);
  import twws_pkg::*;

  // a result only follows a cycle of work
  a_res_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without preceding work");

  // every status other than a finished query carries zero fields
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STAT_OK) |->
      (out_mean == 16'sd0 && out_std_dev == 16'd0 && out_window_weight == 26'd0))
    else $error("nonzero fields with non-ok status");

  // status codes stay in range
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STAT_OK || out_status == STAT_NODATA ||
                   out_status == STAT_ZEROW || out_status == STAT_ADDED ||
                   out_status == STAT_FULL))
    else $error("status out of range");

  // one strobe per item
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back to back result strobes");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after transfer");

endmodule

bind timed_window_weighted_stats_unit twws_checker u_twws_checker (.*);
